FILE: rtl/core/poisson_guidance_stencil_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the stencil RTL
// ---------------------------------------------------------------------------
`ifndef POISSON_GUIDANCE_STENCIL_DEFINES_SVH
`define POISSON_GUIDANCE_STENCIL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/psn_pkg.sv
// ---------------------------------------------------------------------------
// psn_pkg
// Types and constants of the masked five-point stencil block.
// ---------------------------------------------------------------------------
package psn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int GRAD_W     = 11;
  localparam int BSUM_W     = 10;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ = SIZE_W'(MAX_HEIGHT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PADDED_WIDTH  = 2'd0,
    CFG_PADDED_HEIGHT = 2'd1,
    CFG_MIXED_MODE    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic       mask;
    logic [7:0] tgt;
    logic [7:0] src;
  } pixel_t;

  // One line buffer entry: the row two above and the row above, same column.
  typedef struct packed {
    pixel_t two;
    pixel_t one;
  } line_word_t;

  typedef struct packed {
    pixel_t center;
    pixel_t left;
    pixel_t right;
    pixel_t top;
    pixel_t bottom;
  } window_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] guidance;
    logic        [BSUM_W-1:0] boundary_sum;
    logic                     center_in_mask;
  } result_t;

endpackage

FILE: rtl/core/psn_lbuf.sv
// ---------------------------------------------------------------------------
// psn_lbuf
// Two-line buffer: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module psn_lbuf
  import psn_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  line_word_t        wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output line_word_t        rd_data_a,
  output line_word_t        rd_data_b
);

  line_word_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: rtl/core/psn_calc.sv
// ---------------------------------------------------------------------------
// psn_calc
// Masked Laplacian, mixed-gradient choice and outside-neighbour target sum.
// ---------------------------------------------------------------------------
module psn_calc
  import psn_pkg::*;
(
  input  window_t                  win,
  input  logic                     mixed_mode,
  input  logic signed [GRAD_W-1:0] other_gradient,
  output result_t                  res
);

  logic signed [GRAD_W:0]   lap;
  logic        [GRAD_W-1:0] lap_mag;
  logic        [GRAD_W-1:0] other_mag;
  logic                     pick_other;
  logic        [BSUM_W-1:0] t_left;
  logic        [BSUM_W-1:0] t_right;
  logic        [BSUM_W-1:0] t_top;
  logic        [BSUM_W-1:0] t_bottom;

  assign lap = $signed({2'b00, win.center.src, 2'b00})
             - $signed({4'b0000, win.left.src})
             - $signed({4'b0000, win.right.src})
             - $signed({4'b0000, win.top.src})
             - $signed({4'b0000, win.bottom.src});

  assign lap_mag   = lap[GRAD_W] ? GRAD_W'(-lap) : lap[GRAD_W-1:0];
  // most negative code gives 1024, which still fits unsigned
  assign other_mag = other_gradient[GRAD_W-1] ? (~other_gradient + 1'b1)
                                              : other_gradient;

  // ties go to the supplied gradient
  assign pick_other = mixed_mode && !(lap_mag > other_mag);

  assign t_left   = win.left.mask   ? '0 : BSUM_W'(win.left.tgt);
  assign t_right  = win.right.mask  ? '0 : BSUM_W'(win.right.tgt);
  assign t_top    = win.top.mask    ? '0 : BSUM_W'(win.top.tgt);
  assign t_bottom = win.bottom.mask ? '0 : BSUM_W'(win.bottom.tgt);

  always_comb begin
    res.center_in_mask = win.center.mask;
    if (win.center.mask) begin
      res.guidance     = pick_other ? other_gradient : lap[GRAD_W-1:0];
      res.boundary_sum = t_left + t_right + t_top + t_bottom;
    end else begin
      res.guidance     = '0;
      res.boundary_sum = '0;
    end
  end

endmodule

FILE: rtl/core/poisson_guidance_stencil.sv
// ---------------------------------------------------------------------------
// poisson_guidance_stencil
// Masked five-point Laplacian over a raster stream of a padded image.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel takes one pixel word per cycle in raster order, margin
//   included: source value, target value, region mask bit and the supplied
//   gradient for the inner pixel that this word completes. A word arriving
//   below an inner pixel (row >= 2, column 1 .. width-2) yields one result
//   word for that pixel; margin positions yield none.
//   Throughput is one pixel per cycle unless the receiver stalls. A result
//   is registered at the output in the cycle after its pixel is accepted.
//   The window comes from a two-line buffer with two registered read ports,
//   prefetched one column ahead, so each pixel's window is ready on arrival.
//   When the receiver stalls, the output register holds; pixels that produce
//   no result are still taken, and the first pixel that would produce one
//   waits until the output register is free.
//   Reset clears the column and row counters, the left pixel, the output
//   valid flag and the size and mode registers (3 x 3, plain Laplacian mode).
//   The line buffer is not cleared; the first two rows of a frame fill it.
//   Write the size and mode registers only while the block is idle.
// ---------------------------------------------------------------------------
`include "poisson_guidance_stencil_defines.svh"

module poisson_guidance_stencil
  import psn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SIZE_W-1:0]        cfg_wdata,
  // pixel input
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_src_value,
  input  logic [7:0]               in_tgt_value,
  input  logic                     in_in_mask,
  input  logic signed [GRAD_W-1:0] in_other_gradient,
  // result output
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [GRAD_W-1:0] out_guidance,
  output logic [BSUM_W-1:0]        out_boundary_sum,
  output logic                     out_center_in_mask,
  output logic                     out_last
);

  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              mixed_r;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  pixel_t            left_r;

  logic              emit_here;
  logic              col_wrap;
  logic              is_last;
  logic              in_fire;

  pixel_t            pix;
  line_word_t        rd_a;
  line_word_t        rd_b;
  line_word_t        wr_word;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;

  window_t           win;
  result_t           res;
  result_t           out_r;
  logic              out_last_r;
  logic              out_valid_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= MIN_SIZE;
      height_r <= MIN_SIZE;
      mixed_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PADDED_WIDTH:  width_r  <= cfg_wdata;
        CFG_PADDED_HEIGHT: height_r <= cfg_wdata;
        CFG_MIXED_MODE:    mixed_r  <= cfg_wdata[0];
        default:           ;
      endcase
    end
  end

  assign w_eff = (width_r < MIN_SIZE) ? MIN_SIZE :
                 (width_r > MAX_WIDTH_SZ) ? MAX_WIDTH_SZ : width_r;
  assign h_eff = (height_r < MIN_SIZE) ? MIN_SIZE :
                 (height_r > MAX_HEIGHT_SZ) ? MAX_HEIGHT_SZ : height_r;

  // position decode
  assign emit_here = (row_r >= ROW_W'(2)) && (col_r != '0)
                  && (SIZE_W'(col_r) <= w_eff - SIZE_W'(2));
  assign col_wrap  = SIZE_W'(col_r) >= w_eff - SIZE_W'(1);
  assign is_last   = (SIZE_W'(row_r) == h_eff - SIZE_W'(1))
                  && (SIZE_W'(col_r) == w_eff - SIZE_W'(2));

  // stall only a word that must land in a busy output register
  assign in_ready = !emit_here || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = (SIZE_W'(row_r) >= h_eff - SIZE_W'(1)) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_fire) begin
        left_r <= rd_a.one;
      end
    end
  end

  // line buffer: prefetch the next column and its right neighbor
  assign pix       = '{mask: in_in_mask, tgt: in_tgt_value, src: in_src_value};
  assign rd_addr_a = col_nxt;
  assign rd_addr_b = col_nxt + 1'b1;
  assign wr_word   = '{two: rd_a.one, one: pix};

  psn_lbuf u_lbuf (
    .clk       (clk),
    .wr_en     (in_fire),
    .wr_addr   (col_r),
    .wr_data   (wr_word),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign win = '{center: rd_a.one, left: left_r, right: rd_b.one,
                 top: rd_a.two, bottom: pix};

  psn_calc u_calc (
    .win            (win),
    .mixed_mode     (mixed_r),
    .other_gradient (in_other_gradient),
    .res            (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit_here) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit_here) begin
      out_r      <= res;
      out_last_r <= is_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_guidance       = out_r.guidance;
  assign out_boundary_sum   = out_r.boundary_sum;
  assign out_center_in_mask = out_r.center_in_mask;
  assign out_last           = out_last_r;

  `PSN_ASSERT_NOW(a_outside_zero, out_valid_r && !out_r.center_in_mask,
    out_r.guidance == '0 && out_r.boundary_sum == '0,
    "result outside region carries nonzero data")

  `PSN_ASSERT_NOW(a_ready_only_on_stall, !in_ready,
    out_valid_r && !out_ready && emit_here,
    "input held back without an output stall")

  `PSN_ASSERT_NEXT(a_emit_lands, in_fire && emit_here,
    out_valid_r,
    "accepted word with a result did not reach the output register")

  `PSN_ASSERT_NOW(a_no_rw_collision, in_fire,
    col_r != rd_addr_a && col_r != rd_addr_b,
    "line buffer write collides with a prefetch read")

endmodule
